// File: rtl/core/rsi_pkg.sv
// shared widths and sideband types for the ray-sphere intersection pipeline
// used by the square-root cells, the divider cells and the top level
`default_nettype none

package rsi_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned RAD_W   = 31;
  localparam int unsigned T_W     = 31;

  localparam int unsigned BM_W    = 65;
  localparam int unsigned L2_W    = 66;
  localparam int unsigned DD_W    = 64;
  localparam int unsigned PQ_W    = 130;
  localparam int unsigned DISC_W  = 132;
  localparam int unsigned ROOT_W  = DISC_W / 2;
  localparam int unsigned SREM_W  = ROOT_W + 2;
  localparam int unsigned N_W     = ROOT_W + 1;
  localparam int unsigned DREM_W  = DD_W;

  typedef struct packed {
    logic            hit;
    logic            in_sphere;
    logic            bneg;
    logic [BM_W-1:0] bm;
    logic [DD_W-1:0] dd;
  } sq_side_t;

  typedef struct packed {
    logic hit;
    logic in_sphere;
    logic sat;
  } dv_side_t;

endpackage

`default_nettype wire

// File: rtl/core/rsi_sqrt_cell.sv
// one restoring square-root cell: two radicand bits in, one root bit out
// depends on rsi_pkg
`default_nettype none

module rsi_sqrt_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [rsi_pkg::DISC_W-1:0]  rad_in,
  input  wire logic [rsi_pkg::SREM_W-1:0]  rem_in,
  input  wire logic [rsi_pkg::ROOT_W-1:0]  root_in,
  output logic      [rsi_pkg::DISC_W-1:0]  rad_out,
  output logic      [rsi_pkg::SREM_W-1:0]  rem_out,
  output logic      [rsi_pkg::ROOT_W-1:0]  root_out
);

  logic [rsi_pkg::SREM_W+1:0] shifted;
  logic [rsi_pkg::SREM_W+1:0] trial;
  logic                       ge;

  always_comb begin
    shifted = {rem_in, rad_in[rsi_pkg::DISC_W-1 -: 2]};
    trial   = {2'b00, root_in, 2'b01};
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_out  <= {rad_in[rsi_pkg::DISC_W-3:0], 2'b00};
      rem_out  <= ge ? rsi_pkg::SREM_W'(shifted - trial) : rsi_pkg::SREM_W'(shifted);
      root_out <= {root_in[rsi_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rsi_div_cell.sv
// one restoring divider cell: one numerator bit in, one quotient bit out
// depends on rsi_pkg
`default_nettype none

module rsi_div_cell (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [rsi_pkg::DREM_W-1:0]  rem_in,
  input  wire logic [rsi_pkg::T_W-1:0]     lo_in,
  input  wire logic [rsi_pkg::T_W-1:0]     quo_in,
  input  wire logic [rsi_pkg::DD_W-1:0]    dd_in,
  output logic      [rsi_pkg::DREM_W-1:0]  rem_out,
  output logic      [rsi_pkg::T_W-1:0]     lo_out,
  output logic      [rsi_pkg::T_W-1:0]     quo_out,
  output logic      [rsi_pkg::DD_W-1:0]    dd_out
);

  logic [rsi_pkg::DREM_W:0] shifted;
  logic                     ge;

  always_comb begin
    shifted = {rem_in, lo_in[rsi_pkg::T_W-1]};
    ge      = shifted >= {1'b0, dd_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rsi_pkg::DREM_W'(shifted - {1'b0, dd_in})
                    : rsi_pkg::DREM_W'(shifted);
      lo_out  <= {lo_in[rsi_pkg::T_W-2:0], 1'b0};
      quo_out <= {quo_in[rsi_pkg::T_W-2:0], ge};
      dd_out  <= dd_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ray_sphere_intersect_top.sv
// ray-sphere intersection, geometric method, one test per word
// pipeline: 7 dot-product stages, 66 square-root cells, 2 stages, 31 divider cells, out
// throughput one word per cycle; the whole pipeline holds when the output word is not taken
// synchronous active-high reset clears the valid pipeline only
// depends on rsi_pkg, rsi_sqrt_cell, rsi_div_cell
`default_nettype none

module ray_sphere_intersect_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y, center_z, radius
  input  wire logic [319:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // hit_distance
  output logic [31:0]       m_tdata,
  // hit, origin_inside
  output logic [1:0]        m_tuser
);

  localparam int unsigned LAT   = 7 + rsi_pkg::ROOT_W + 2 + rsi_pkg::T_W + 1;
  localparam int unsigned NUM_W = rsi_pkg::N_W + FRAC_BITS;

  logic           en;
  logic [LAT-1:0] vpipe;

  assign en       = !vpipe[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: offsets and magnitudes
  logic [32:0] ml [3];
  logic [31:0] md [3];
  logic [2:0]  sgn;
  logic [rsi_pkg::RAD_W-1:0] r1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [32:0] o, c, l, d;
        o = 33'(signed'(s_tdata[32*k +: 32]));
        d = 33'(signed'(s_tdata[32*(3+k) +: 32]));
        c = 33'(signed'(s_tdata[32*(6+k) +: 32]));
        l = c - o;
        ml[k]  <= l[32] ? 33'(-l) : 33'(l);
        md[k]  <= d[32] ? 32'(-d) : 32'(d);
        sgn[k] <= l[32] ^ d[32];
      end
      r1 <= s_tdata[288 +: rsi_pkg::RAD_W];
    end
  end

  // stage 2: products
  logic [63:0] pld [3];
  logic [64:0] pll [3];
  logic [63:0] pdd [3];
  logic [2:0]  sgn2;
  logic [61:0] r2_2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [64:0] a, b;
        logic [63:0] e;
        a = ml[k] * md[k];
        b = ml[k] * ml[k];
        e = md[k] * md[k];
        pld[k] <= a[63:0];
        pll[k] <= b;
        pdd[k] <= e;
      end
      sgn2 <= sgn;
      r2_2 <= r1 * r1;
    end
  end

  // stage 3: dot products
  logic [rsi_pkg::BM_W-1:0] bpos, bneg;
  logic [rsi_pkg::L2_W-1:0] l2;
  logic [rsi_pkg::DD_W-1:0] dd3;
  logic [61:0]              r2_3;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [rsi_pkg::BM_W-1:0] sp, sn;
      logic [rsi_pkg::L2_W-1:0] sl;
      logic [rsi_pkg::DD_W-1:0] sd;
      sp = '0; sn = '0; sl = '0; sd = '0;
      for (int k = 0; k < 3; k++) begin
        if (sgn2[k]) sn = sn + rsi_pkg::BM_W'(pld[k]);
        else         sp = sp + rsi_pkg::BM_W'(pld[k]);
        sl = sl + rsi_pkg::L2_W'(pll[k]);
        sd = sd + pdd[k];
      end
      bpos <= sp;
      bneg <= sn;
      l2   <= sl;
      dd3  <= sd;
      r2_3 <= r2_2;
    end
  end

  // stage 4: inside test, |b| and |l2 - r2|
  logic                     inside4, bneg4;
  logic [rsi_pkg::BM_W-1:0] bm4;
  logic [rsi_pkg::L2_W-1:0] dt4;
  logic [rsi_pkg::DD_W-1:0] dd4;

  always_ff @(posedge clk) begin
    if (en) begin
      logic ins, bn;
      ins = l2 < rsi_pkg::L2_W'(r2_3);
      bn  = bpos < bneg;
      inside4 <= ins;
      bneg4   <= bn;
      bm4     <= bn ? bneg - bpos : bpos - bneg;
      dt4     <= ins ? rsi_pkg::L2_W'(r2_3) - l2 : l2 - rsi_pkg::L2_W'(r2_3);
      dd4     <= dd3;
    end
  end

  // stage 5: partial products
  logic [65:0] pll5;
  logic [64:0] plh5;
  logic [63:0] phh5;
  logic [64:0] q00, q01, q10, q11;
  logic        inside5, bneg5;
  logic [rsi_pkg::BM_W-1:0] bm5;
  logic [rsi_pkg::DD_W-1:0] dd5;

  always_ff @(posedge clk) begin
    if (en) begin
      pll5 <= bm4[32:0] * bm4[32:0];
      plh5 <= bm4[32:0] * bm4[64:33];
      phh5 <= bm4[64:33] * bm4[64:33];
      q00  <= dd4[31:0] * dt4[32:0];
      q01  <= dd4[31:0] * dt4[65:33];
      q10  <= dd4[63:32] * dt4[32:0];
      q11  <= dd4[63:32] * dt4[65:33];
      inside5 <= inside4;
      bneg5   <= bneg4;
      bm5     <= bm4;
      dd5     <= dd4;
    end
  end

  // stage 6: b*b and dd*|l2 - r2|
  logic [rsi_pkg::PQ_W-1:0] p6, q6;
  logic                     inside6, bneg6;
  logic [rsi_pkg::BM_W-1:0] bm6;
  logic [rsi_pkg::DD_W-1:0] dd6;

  always_ff @(posedge clk) begin
    if (en) begin
      p6 <= (rsi_pkg::PQ_W'(phh5) << 66) + (rsi_pkg::PQ_W'(plh5) << 34)
            + rsi_pkg::PQ_W'(pll5);
      q6 <= (rsi_pkg::PQ_W'(q11) << 65) + (rsi_pkg::PQ_W'(q10) << 32)
            + (rsi_pkg::PQ_W'(q01) << 33) + rsi_pkg::PQ_W'(q00);
      inside6 <= inside5;
      bneg6   <= bneg5;
      bm6     <= bm5;
      dd6     <= dd5;
    end
  end

  // stage 7 feeds the square-root chain
  logic [rsi_pkg::DISC_W-1:0] sq_rad  [rsi_pkg::ROOT_W+1];
  logic [rsi_pkg::SREM_W-1:0] sq_rem  [rsi_pkg::ROOT_W+1];
  logic [rsi_pkg::ROOT_W-1:0] sq_root [rsi_pkg::ROOT_W+1];
  rsi_pkg::sq_side_t          sq_sb   [rsi_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad[0]          <= inside6 ? rsi_pkg::DISC_W'(p6) + rsi_pkg::DISC_W'(q6)
                                    : rsi_pkg::DISC_W'(p6) - rsi_pkg::DISC_W'(q6);
      sq_rem[0]          <= '0;
      sq_root[0]         <= '0;
      sq_sb[0].hit       <= (dd6 != '0) && (inside6 || (!bneg6 && p6 >= q6));
      sq_sb[0].in_sphere <= inside6;
      sq_sb[0].bneg      <= bneg6;
      sq_sb[0].bm        <= bm6;
      sq_sb[0].dd        <= dd6;
    end
  end

  for (genvar i = 0; i < rsi_pkg::ROOT_W; i++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) sq_sb[i+1] <= sq_sb[i];
    end
  end

  // stage 8: numerator
  logic [rsi_pkg::N_W-1:0] n8;
  rsi_pkg::sq_side_t       sb8;

  always_ff @(posedge clk) begin
    if (en) begin
      logic [rsi_pkg::N_W-1:0] s, b;
      s = rsi_pkg::N_W'(sq_root[rsi_pkg::ROOT_W]);
      b = rsi_pkg::N_W'(sq_sb[rsi_pkg::ROOT_W].bm);
      if (sq_sb[rsi_pkg::ROOT_W].in_sphere && !sq_sb[rsi_pkg::ROOT_W].bneg) n8 <= b + s;
      else if (sq_sb[rsi_pkg::ROOT_W].in_sphere) n8 <= (s >= b) ? s - b : '0;
      else n8 <= (b >= s) ? b - s : '0;
      sb8 <= sq_sb[rsi_pkg::ROOT_W];
    end
  end

  // stage 9 feeds the divider chain
  logic [NUM_W-1:0] num9;
  logic [rsi_pkg::DREM_W-1:0] dv_rem [rsi_pkg::T_W+1];
  logic [rsi_pkg::T_W-1:0]    dv_lo  [rsi_pkg::T_W+1];
  logic [rsi_pkg::T_W-1:0]    dv_quo [rsi_pkg::T_W+1];
  logic [rsi_pkg::DD_W-1:0]   dv_dd  [rsi_pkg::T_W+1];
  rsi_pkg::dv_side_t          dv_sb  [rsi_pkg::T_W+1];

  assign num9 = {n8, {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      logic [rsi_pkg::DREM_W-1:0] top;
      top = rsi_pkg::DREM_W'(num9 >> rsi_pkg::T_W);
      dv_rem[0]          <= top;
      dv_lo[0]           <= num9[rsi_pkg::T_W-1:0];
      dv_quo[0]          <= '0;
      dv_dd[0]           <= sb8.dd;
      dv_sb[0].hit       <= sb8.hit;
      dv_sb[0].in_sphere <= sb8.in_sphere;
      dv_sb[0].sat       <= top >= sb8.dd;
    end
  end

  for (genvar j = 0; j < rsi_pkg::T_W; j++) begin : g_div
    rsi_div_cell u_cell (
      .clk     (clk),
      .en      (en),
      .rem_in  (dv_rem[j]),
      .lo_in   (dv_lo[j]),
      .quo_in  (dv_quo[j]),
      .dd_in   (dv_dd[j]),
      .rem_out (dv_rem[j+1]),
      .lo_out  (dv_lo[j+1]),
      .quo_out (dv_quo[j+1]),
      .dd_out  (dv_dd[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) dv_sb[j+1] <= dv_sb[j];
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (en) begin
      if (!dv_sb[rsi_pkg::T_W].hit) m_tdata <= '0;
      else if (dv_sb[rsi_pkg::T_W].sat) m_tdata <= {1'b0, {rsi_pkg::T_W{1'b1}}};
      else m_tdata <= {1'b0, dv_quo[rsi_pkg::T_W]};
      m_tuser <= {dv_sb[rsi_pkg::T_W].in_sphere, dv_sb[rsi_pkg::T_W].hit};
    end
  end

`ifndef ASSERT_OFF
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("miss with nonzero distance");

  a_top_bit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[31])
    else $error("distance exceeds range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("pipeline moved while held");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vpipe[0])
    else $error("accepted word not tracked");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
// self-checking testbench for ray_sphere_intersect_top: directed table then random rays
// expected words come from the directed table or a local exact-integer predictor; depends on the rtl
`default_nettype none

module testbench;

  localparam int unsigned FRAC = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 150;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam logic [30:0] T_SAT = 31'h7FFFFFFF;
  localparam int ONE = 65536;

  typedef struct packed {
    logic        hit;
    logic        in_sphere;
    logic [30:0] distance;
  } hit_rec_t;

  typedef struct {
    logic [319:0] word;
    bit           typed;
    hit_rec_t     res;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [319:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0] m_tuser;

  logic in_acc = 1'b0;
  logic out_acc = 1'b0;
  logic [31:0] smp_tdata;
  logic [1:0] smp_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  hit_rec_t hits_due[$];
  ray_row_t rays[$];

  ray_sphere_intersect_top #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshakes are sampled mid-cycle and acted on at the next rising edge
  always @(negedge clk) begin
    in_acc = s_tvalid && s_tready;
    out_acc = m_tvalid && m_tready;
    smp_tdata = m_tdata;
    smp_tuser = m_tuser;
  end

  function automatic logic [319:0] pack_ray(input int ox, oy, oz, dx, dy, dz, cx, cy, cz,
                                            input logic [30:0] r);
    return {1'b0, r, cz, cy, cx, dz, dy, dx, oz, oy, ox};
  endfunction

  function automatic logic [69:0] int_sqrt(input logic [139:0] a);
    logic [139:0] root;
    logic [139:0] cand;
    root = '0;
    for (int i = 69; i >= 0; i--) begin
      cand = root | (140'd1 << i);
      if (cand * cand <= a) root = cand;
    end
    return root[69:0];
  endfunction

  function automatic hit_rec_t predict_hit(input logic [319:0] w);
    logic signed [67:0] lk, dk, b;
    logic [67:0] l2, bm;
    logic [63:0] dd;
    logic [61:0] r2;
    logic [30:0] r;
    logic [139:0] p, q, diff, disc;
    logic [69:0] s, n;
    logic [159:0] num, quo;
    hit_rec_t res;
    b = '0;
    l2 = '0;
    dd = '0;
    for (int k = 0; k < 3; k++) begin
      lk = $signed(w[32*(6+k) +: 32]);
      lk = lk - 68'($signed(w[32*k +: 32]));
      dk = $signed(w[32*(3+k) +: 32]);
      b = b + lk * dk;
      l2 = l2 + 68'(lk * lk);
      dd = dd + 64'(dk * dk);
    end
    r = w[318:288];
    r2 = r * r;
    res = '0;
    res.in_sphere = l2 < 68'(r2);
    bm = b < 0 ? 68'(-b) : 68'(b);
    if (dd != 0) begin
      p = bm * bm;
      diff = res.in_sphere ? 140'(r2) - 140'(l2) : 140'(l2) - 140'(r2);
      q = dd * diff;
      n = '0;
      if (res.in_sphere) begin
        s = int_sqrt(p + q);
        if (b >= 0) n = bm + s;
        else if (s >= bm) n = s - bm;
        res.hit = 1'b1;
      end else if (b >= 0 && p >= q) begin
        disc = p - q;
        s = int_sqrt(disc);
        if (bm >= s) n = bm - s;
        res.hit = 1'b1;
      end
      if (res.hit) begin
        num = n;
        num = num << FRAC;
        quo = num / dd;
        res.distance = quo > 160'(T_SAT) ? T_SAT : quo[30:0];
      end
    end
    return res;
  endfunction

  function automatic int rand_span(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic logic [319:0] random_ray();
    int o[3], c[3], d[3];
    int sel, rad;
    sel = $urandom_range(99);
    if (sel < 15) begin
      return {1'b0, 31'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end
    if (sel < 25) begin
      for (int k = 0; k < 3; k++) begin
        o[k] = rand_span(40);
        c[k] = rand_span(40);
        d[k] = rand_span(4);
      end
      return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2],
                      31'($urandom_range(40)));
    end
    rad = $urandom_range(60 * ONE);
    for (int k = 0; k < 3; k++) begin
      c[k] = rand_span(200 * ONE);
      if (sel < 45) o[k] = c[k] + rand_span(rad / 2);
      else o[k] = rand_span(200 * ONE);
    end
    for (int k = 0; k < 3; k++) begin
      if (sel < 80) d[k] = (c[k] - o[k]) / 8 + rand_span(rad / 4);
      else d[k] = rand_span(4 * ONE);
    end
    return pack_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2], 31'(rad));
  endfunction

  task automatic send_ray(input logic [319:0] w, input bit typed, input hit_rec_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk); while (!in_acc);
    hits_due = {hits_due, (typed ? res : predict_hit(w))};
  endtask

  task automatic add_row(input logic [319:0] w, input bit typed, input hit_rec_t res);
    ray_row_t row;
    row.word = w;
    row.typed = typed;
    row.res = res;
    rays = {rays, row};
  endtask

  always @(posedge clk) begin
    hit_rec_t due;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
    if (out_acc) begin
      if (hits_due.size() == 0) begin
        $error("unexpected word: tdata %h tuser %b", smp_tdata, smp_tuser);
        fail_count = fail_count + 1;
      end else begin
        due = hits_due.pop_front();
        if (smp_tuser[0] !== due.hit) begin
          $error("hit: expected %0d actual %0d", due.hit, smp_tuser[0]);
          fail_count = fail_count + 1;
        end
        if (smp_tuser[1] !== due.in_sphere) begin
          $error("origin_inside: expected %0d actual %0d", due.in_sphere, smp_tuser[1]);
          fail_count = fail_count + 1;
        end
        if (smp_tdata !== {1'b0, due.distance}) begin
          $error("hit_distance: expected %h actual %h", due.distance, smp_tdata);
          fail_count = fail_count + 1;
        end
      end
    end
    if (!rst) m_tready <= $urandom_range(99) >= recv_stall_pct;
  end

  initial begin
    int unsigned idle_tab[4] = '{0, 45, 0, 24};
    int unsigned stall_tab[4] = '{0, 0, 45, 24};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero ray, zero direction inside, tangent, on surface, behind, inside, saturation
    add_row('0, 1, '{1'b0, 1'b0, 31'd0});
    add_row(pack_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'(ONE)), 1, '{1'b0, 1'b1, 31'd0});
    add_row(pack_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 5 * ONE, 0, 31'(5 * ONE)), 1,
            '{1'b1, 1'b0, 31'(10 * ONE)});
    add_row(pack_ray(5 * ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, 31'(5 * ONE)), 1,
            '{1'b1, 1'b0, 31'd0});
    add_row(pack_ray(0, 0, 0, -ONE, 0, 0, 10 * ONE, 0, 0, 31'(ONE)), 1,
            '{1'b0, 1'b0, 31'd0});
    add_row(pack_ray(ONE, ONE, ONE, ONE, 0, 0, ONE, ONE, ONE, 31'(2 * ONE)), 1,
            '{1'b1, 1'b1, 31'(2 * ONE)});
    add_row(pack_ray(0, 0, 0, 1, 0, 0, 32'h7FFFFFFF, 0, 0, 31'd1), 1,
            '{1'b1, 1'b0, T_SAT});
    add_row({1'b0, {31{1'b1}}, {288{1'b1}}}, 0, '0);
    add_row({1'b0, 31'd0, {9{32'h80000000}}}, 0, '0);
    add_row(pack_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 31'h7FFFFFFF), 0, '0);
    add_row(pack_ray(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0,
                     31'h7FFFFFFF), 0, '0);
    add_row(pack_ray(0, 0, 0, 0, 0, ONE, 0, 0, 3 * ONE, 31'd0), 0, '0);

    foreach (rays[i]) send_ray(rays[i].word, rays[i].typed, rays[i].res);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_ray(random_ray(), 0, '0);
    end
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (hits_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
